[rtl/tsv_pkg.sv]
`timescale 1ns / 1ps

package tsv_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 3;
    localparam logic [2:0]  CFG_NUMBER   = 3'd0;
    localparam logic [2:0]  CFG_SQUEEZE  = 3'd1;
    localparam logic [2:0]  CFG_ENDS     = 3'd2;
    localparam logic [2:0]  CFG_TABS     = 3'd3;
    localparam logic [2:0]  CFG_NONPRINT = 3'd4;

    // Character codes
    localparam logic [7:0] CHAR_NL      = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
    localparam logic [7:0] CHAR_CARET   = 8'd94;
    localparam logic [7:0] CHAR_I       = 8'd73;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] PRINT_LO     = 8'd32;
    localparam logic [7:0] PRINT_HI     = 8'd126;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    // Option flags
    typedef struct packed {
        logic number_enable;
        logic squeeze_enable;
        logic ends_enable;
        logic tabs_enable;
        logic nonprint_enable;
    } t_cfg;

    // Control part of one decoded transaction: number prefix and body bytes
    typedef struct packed {
        logic       has_num;
        logic [1:0] body_cnt;
        logic [7:0] body0;
        logic [7:0] body1;
    } t_item_ctl;

endpackage

[rtl/text_stream_visualizer_top.sv]
`timescale 1ns / 1ps
// Accepted bytes go to the transaction register; result bytes leave from the output register.
// Throughput: one result byte per cycle unless the output stalls; the transaction register
// holds a byte until its last result enters the output register; a no-result byte frees it.
// Without stalls, single-result bytes flow at one per cycle; the byte walker sets the rate.
// Reset (synchronous, active low): options off, line start set, line number 1, no data held.

module text_stream_visualizer_top #(
    parameter int COUNT_DIGITS = 9,
    parameter int PAD_WIDTH    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last
);
    import tsv_pkg::*;

    localparam int FIELD_MAX = (COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH;
    localparam int CW        = $clog2(FIELD_MAX + 1);

    t_cfg                    r_cfg;
    logic                    accept;
    t_item_ctl               item_ctl;
    logic [4*COUNT_DIGITS-1:0] item_bcd;
    logic [CW-1:0]           item_ndig;

    // Write option registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUMBER:   r_cfg.number_enable   <= i_cfg_data;
                CFG_SQUEEZE:  r_cfg.squeeze_enable  <= i_cfg_data;
                CFG_ENDS:     r_cfg.ends_enable     <= i_cfg_data;
                CFG_TABS:     r_cfg.tabs_enable     <= i_cfg_data;
                CFG_NONPRINT: r_cfg.nonprint_enable <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign accept = i_in_valid && !o_in_stall;

    tsv_front #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .PAD_WIDTH    (PAD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_ctl       (item_ctl),
        .o_bcd       (item_bcd),
        .o_ndig      (item_ndig)
    );

    tsv_emit #(
        .COUNT_DIGITS (COUNT_DIGITS),
        .PAD_WIDTH    (PAD_WIDTH)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_ctl       (item_ctl),
        .i_bcd       (item_bcd),
        .i_ndig      (item_ndig),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

[rtl/tsv_front.sv]
`timescale 1ns / 1ps

module tsv_front #(
    parameter int COUNT_DIGITS = 9,
    parameter int PAD_WIDTH    = 6
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  tsv_pkg::t_cfg                                i_cfg,
    input  logic                                         i_accept,
    input  logic [7:0]                                   i_data_byte,
    output tsv_pkg::t_item_ctl                           o_ctl,
    output logic [4*COUNT_DIGITS-1:0]                    o_bcd,
    output logic [$clog2(((COUNT_DIGITS > PAD_WIDTH) ?
                 COUNT_DIGITS : PAD_WIDTH) + 1)-1:0]     o_ndig
);
    import tsv_pkg::*;

    localparam int CNT_W     = 4 * COUNT_DIGITS;
    localparam int FIELD_MAX = (COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH;
    localparam int CW        = $clog2(FIELD_MAX + 1);

    logic             r_at_line_start;
    logic             r_first_blank;
    logic [CNT_W-1:0] r_count;

    logic             n_at_line_start;
    logic             n_first_blank;
    logic [CNT_W-1:0] n_count;

    logic             is_nl;
    logic             is_blank;
    logic             all_nine;
    logic [CNT_W-1:0] count_inc;
    logic [CW-1:0]    ndig;
    t_item_ctl        ctl;

    assign is_nl    = (i_data_byte == CHAR_NL);
    assign is_blank = r_at_line_start && i_cfg.squeeze_enable && is_nl;

    // Saturating BCD increment: a digit rolls when every lower digit is nine
    always_comb begin
        logic carry;
        carry     = 1'b1;
        all_nine  = 1'b1;
        count_inc = r_count;
        for (int d = 0; d < COUNT_DIGITS; d++) begin
            if (r_count[4*d +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                count_inc[4*d +: 4] = (r_count[4*d +: 4] == 4'd9) ? 4'd0
                                    : r_count[4*d +: 4] + 4'd1;
            end
            carry = carry && (r_count[4*d +: 4] == 4'd9);
        end
        if (all_nine) begin
            count_inc = r_count;
        end
    end

    // Count significant digits of the current line number
    always_comb begin
        ndig = CW'(1);
        for (int d = 0; d < COUNT_DIGITS; d++) begin
            if (r_count[4*d +: 4] != 4'd0) begin
                ndig = CW'(d + 1);
            end
        end
    end

    // Decode the byte into prefix and body and compute the next line state
    always_comb begin
        ctl             = '0;
        ctl.body0       = i_data_byte;
        ctl.body1       = i_data_byte;
        n_at_line_start = r_at_line_start;
        n_first_blank   = r_first_blank;
        n_count         = r_count;
        if (is_blank) begin
            ctl.body0 = CHAR_NL;
            if (i_cfg.number_enable) begin
                ctl.body_cnt = 2'd1;
            end else if (r_first_blank) begin
                ctl.body_cnt  = 2'd1;
                n_first_blank = 1'b0;
            end
        end else begin
            n_first_blank   = 1'b1;
            n_at_line_start = is_nl;
            ctl.has_num     = r_at_line_start && i_cfg.number_enable;
            if (ctl.has_num) begin
                n_count = count_inc;
            end
            if (i_cfg.ends_enable && is_nl) begin
                ctl.body_cnt = 2'd2;
                ctl.body0    = CHAR_DOLLAR;
                ctl.body1    = CHAR_NL;
            end else if (i_cfg.tabs_enable && (i_data_byte == CHAR_TAB)) begin
                ctl.body_cnt = 2'd2;
                ctl.body0    = CHAR_CARET;
                ctl.body1    = CHAR_I;
            end else if (i_cfg.nonprint_enable && !is_nl && (i_data_byte != CHAR_TAB)
                         && ((i_data_byte < PRINT_LO) || (i_data_byte > PRINT_HI))) begin
                ctl.body_cnt = 2'd2;
                ctl.body0    = CHAR_CARET;
                ctl.body1    = i_data_byte + CARET_OFFSET;
            end else begin
                ctl.body_cnt = 2'd1;
            end
        end
    end

    // Hold line state; advance it on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_first_blank   <= 1'b1;
            r_count         <= {{(CNT_W-4){1'b0}}, 4'd1};
        end else if (i_accept) begin
            r_at_line_start <= n_at_line_start;
            r_first_blank   <= n_first_blank;
            r_count         <= n_count;
        end
    end

    assign o_ctl  = ctl;
    assign o_bcd  = r_count;
    assign o_ndig = ndig;

endmodule

[rtl/tsv_emit.sv]
`timescale 1ns / 1ps

module tsv_emit #(
    parameter int COUNT_DIGITS = 9,
    parameter int PAD_WIDTH    = 6
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  tsv_pkg::t_item_ctl                           i_ctl,
    input  logic [4*COUNT_DIGITS-1:0]                    i_bcd,
    input  logic [$clog2(((COUNT_DIGITS > PAD_WIDTH) ?
                 COUNT_DIGITS : PAD_WIDTH) + 1)-1:0]     i_ndig,
    output logic                                         o_in_stall,
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output logic [7:0]                                   o_out_byte,
    output logic                                         o_last
);
    import tsv_pkg::*;

    localparam int CNT_W     = 4 * COUNT_DIGITS;
    localparam int FIELD_MAX = (COUNT_DIGITS > PAD_WIDTH) ? COUNT_DIGITS : PAD_WIDTH;
    localparam int CW        = $clog2(FIELD_MAX + 1);

    typedef enum logic [2:0] {
        PH_NUM,
        PH_SEP0,
        PH_SEP1,
        PH_BODY0,
        PH_BODY1
    } t_phase;

    t_phase           r_phase;
    t_phase           n_phase;
    logic             r_valid;
    t_item_ctl        r_ctl;
    logic [CNT_W-1:0] r_bcd;
    logic [CW-1:0]    r_ndig;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             out_free;
    logic             empty_item;
    logic             step;
    logic             is_last;
    logic             pop;
    logic [3:0]       digit;
    logic [7:0]       cur_byte;
    logic [CW-1:0]    col_start;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign empty_item = !r_ctl.has_num && (r_ctl.body_cnt == 2'd0);
    assign step       = r_valid && out_free && !empty_item;
    assign is_last    = ((r_phase == PH_BODY0) && (r_ctl.body_cnt == 2'd1))
                     || (r_phase == PH_BODY1);
    assign pop        = r_valid && (empty_item || (out_free && is_last));
    assign o_in_stall = r_valid && !pop;

    // Field width: padded to PAD_WIDTH, or the full number when longer
    assign col_start = (i_ndig > CW'(PAD_WIDTH)) ? (i_ndig - CW'(1)) : CW'(PAD_WIDTH - 1);

    // Pick the BCD digit at the current column
    always_comb begin
        digit = 4'd0;
        for (int d = 0; d < COUNT_DIGITS; d++) begin
            if (r_col == CW'(d)) begin
                digit = r_bcd[4*d +: 4];
            end
        end
    end

    // Select the byte for the current phase and the phase that follows
    always_comb begin
        cur_byte = r_ctl.body0;
        n_phase  = r_phase;
        n_col    = r_col;
        unique case (r_phase)
            PH_NUM: begin
                cur_byte = (r_col >= r_ndig) ? CHAR_SPACE : (CHAR_ZERO + {4'd0, digit});
                if (r_col == '0) begin
                    n_phase = PH_SEP0;
                end else begin
                    n_col = r_col - CW'(1);
                end
            end
            PH_SEP0: begin
                cur_byte = CHAR_SPACE;
                n_phase  = PH_SEP1;
            end
            PH_SEP1: begin
                cur_byte = CHAR_SPACE;
                n_phase  = PH_BODY0;
            end
            PH_BODY0: begin
                cur_byte = r_ctl.body0;
                n_phase  = PH_BODY1;
            end
            PH_BODY1: begin
                cur_byte = r_ctl.body1;
            end
            default: begin
                cur_byte = r_ctl.body0;
            end
        endcase
    end

    // Hold the transaction, walk its bytes, and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_phase     <= PH_BODY0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_phase <= i_ctl.has_num ? PH_NUM : PH_BODY0;
            end else if (pop) begin
                r_valid <= 1'b0;
            end else if (step) begin
                r_phase <= n_phase;
            end
            if (out_free) begin
                r_out_valid <= step;
            end
        end
        if (i_load) begin
            r_ctl  <= i_ctl;
            r_bcd  <= i_bcd;
            r_ndig <= i_ndig;
            r_col  <= col_start;
        end else if (step) begin
            r_col <= n_col;
        end
        if (step) begin
            r_out_byte <= cur_byte;
            r_out_last <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    // Number phase only for transactions that carry a line number
    a_num_has_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_phase == PH_NUM)) |-> r_ctl.has_num)
        else $error("number phase without a line number");

    // Second body byte only for two-byte expansions
    a_body1_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_phase == PH_BODY1)) |-> (r_ctl.body_cnt == 2'd2))
        else $error("second body byte on a one-byte transaction");

    // A new transaction never overwrites one still in progress
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || pop))
        else $error("transaction loaded over one still in progress");

    // A numbered transaction always ends with at least one body byte
    a_num_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ctl.has_num) |-> (r_ctl.body_cnt != 2'd0))
        else $error("numbered transaction without a body byte");

endmodule

[verif/tsv_stream_checker.sv]
`timescale 1ns / 1ps

module tsv_stream_checker #(
    parameter int COUNT_DIGITS = 9,
    parameter int PAD_WIDTH    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_out_byte,
    input  logic                          i_last,
    output int                            o_pending,
    output int                            o_fail_count
);
    import tsv_pkg::*;

    localparam int CHARS_MAX = COUNT_DIGITS + PAD_WIDTH + 4;
    localparam int BCD_W     = 4 * COUNT_DIGITS;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_char;

    // Shadow of the option flags and the line state
    t_cfg             opts;
    logic             at_line_start;
    logic             first_blank;
    logic [BCD_W-1:0] line_num_bcd;

    t_out_char expected_chars[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;

    // Advance the BCD line number, holding at all nines
    function automatic logic [BCD_W-1:0] bcd_increment(input logic [BCD_W-1:0] value);
        logic [BCD_W-1:0] result;
        logic             all_nines;
        logic             carry;
        all_nines = 1'b1;
        for (int k = 0; k < COUNT_DIGITS; k++) begin
            if (value[4*k +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
        end
        result = value;
        carry  = !all_nines;
        for (int k = 0; k < COUNT_DIGITS; k++) begin
            if (carry) begin
                if (result[4*k +: 4] == 4'd9) begin
                    result[4*k +: 4] = 4'd0;
                end else begin
                    result[4*k +: 4] = result[4*k +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return result;
    endfunction

    // Work out the output characters of one input byte and queue them
    task automatic predict_chars(input logic [7:0] b);
        logic [7:0] chars [0:CHARS_MAX-1];
        int         n;
        int         ndig;
        n = 0;
        if (at_line_start && opts.squeeze_enable && b == CHAR_NL) begin
            // Blank line: plain newline when numbering, else keep only the first
            if (opts.number_enable) begin
                chars[n] = CHAR_NL;
                n++;
            end else if (first_blank) begin
                first_blank = 1'b0;
                chars[n] = CHAR_NL;
                n++;
            end
        end else begin
            first_blank = 1'b1;
            if (at_line_start && opts.number_enable) begin
                ndig = 1;
                for (int k = 0; k < COUNT_DIGITS; k++) begin
                    if (line_num_bcd[4*k +: 4] != 4'd0) begin
                        ndig = k + 1;
                    end
                end
                for (int k = ndig; k < PAD_WIDTH; k++) begin
                    chars[n] = CHAR_SPACE;
                    n++;
                end
                for (int k = ndig; k > 0; k--) begin
                    chars[n] = CHAR_ZERO + {4'd0, line_num_bcd[4*(k-1) +: 4]};
                    n++;
                end
                chars[n] = CHAR_SPACE;
                n++;
                chars[n] = CHAR_SPACE;
                n++;
                line_num_bcd = bcd_increment(line_num_bcd);
            end
            if (opts.ends_enable && b == CHAR_NL) begin
                chars[n] = CHAR_DOLLAR;
                n++;
                chars[n] = CHAR_NL;
                n++;
            end else if (opts.tabs_enable && b == CHAR_TAB) begin
                chars[n] = CHAR_CARET;
                n++;
                chars[n] = CHAR_I;
                n++;
            end else if (opts.nonprint_enable && b != CHAR_NL && b != CHAR_TAB
                         && (b < PRINT_LO || b > PRINT_HI)) begin
                chars[n] = CHAR_CARET;
                n++;
                chars[n] = b + CARET_OFFSET;
                n++;
            end else begin
                chars[n] = b;
                n++;
            end
            at_line_start = (b == CHAR_NL);
        end
        for (int k = 0; k < n; k++) begin
            expected_chars.push_back('{out_byte: chars[k], last: (k == n - 1)});
        end
    endtask

    // Watch config writes, input and output transactions
    always @(posedge i_clk) begin
        t_out_char head;
        if (!i_rst_n) begin
            opts          = '0;
            at_line_start = 1'b1;
            first_blank   = 1'b1;
            line_num_bcd  = BCD_W'(1);
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUMBER:   opts.number_enable   = i_cfg_data;
                    CFG_SQUEEZE:  opts.squeeze_enable  = i_cfg_data;
                    CFG_ENDS:     opts.ends_enable     = i_cfg_data;
                    CFG_TABS:     opts.tabs_enable     = i_cfg_data;
                    CFG_NONPRINT: opts.nonprint_enable = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_chars(i_data_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual byte %02h last %0b",
                             $time, i_out_byte, i_last);
                    fail_count++;
                end else begin
                    head = expected_chars.pop_front();
                    if (i_out_byte !== head.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, head.out_byte, i_out_byte);
                        fail_count++;
                    end
                    if (i_last !== head.last) begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, head.last, i_last);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tsv_pkg::*;

    localparam int COUNT_DIGITS     = 9;
    localparam int PAD_WIDTH        = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES     = 400000;
    localparam int PHASE_COUNT      = 6;
    localparam int PHASE_ITEMS      = 50;
    localparam int IDLE_HEAVY       = 84;
    localparam int IDLE_BOTH        = 32;

    localparam int FIRST_LEN  = 16;
    localparam int SECOND_LEN = 9;

    // Directed text with every option on: squeezed numbered blank, controls, edges
    localparam logic [0:FIRST_LEN-1][7:0] FIRST_TEXT = {
        CHAR_NL, 8'h41, CHAR_TAB, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF,
        CHAR_SPACE, PRINT_HI, CHAR_NL, CHAR_NL, CHAR_NL, 8'h7A, CHAR_NL, CHAR_NL
    };
    // Directed text with squeezing only: blank runs, raw control and high bytes
    localparam logic [0:SECOND_LEN-1][7:0] SECOND_TEXT = {
        CHAR_NL, CHAR_NL, CHAR_NL, 8'h00, CHAR_TAB, 8'hFF, CHAR_NL, CHAR_NL, CHAR_NL
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data  = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_data_byte = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [7:0]           o_out_byte;
    logic                 o_last;

    int pending;
    int fail_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    text_stream_visualizer_top #(
        .COUNT_DIGITS(COUNT_DIGITS),
        .PAD_WIDTH   (PAD_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    tsv_stream_checker #(
        .COUNT_DIGITS(COUNT_DIGITS),
        .PAD_WIDTH   (PAD_WIDTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_byte  (o_out_byte),
        .i_last      (o_last),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // Stall the output at random; hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= LONG_HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one byte after a random gap and wait until it is taken
    task automatic offer_char(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid, wait for every expected byte, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Write all option flags plus one unused index, which must be ignored
    task automatic apply_opts(input t_cfg c);
        cfg_write(CFG_NUMBER,   c.number_enable);
        cfg_write(CFG_SQUEEZE,  c.squeeze_enable);
        cfg_write(CFG_ENDS,     c.ends_enable);
        cfg_write(CFG_TABS,     c.tabs_enable);
        cfg_write(CFG_NONPRINT, c.nonprint_enable);
        cfg_write(CFG_IDX_W'(CFG_NONPRINT + CFG_IDX_W'($urandom_range(3, 1))), 1'b1);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_text_char();
        case ($urandom_range(9))
            0:       return CHAR_TAB;
            1:       return 8'($urandom_range(31));
            2:       return 8'($urandom_range(255, 127));
            3:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(126, 32));
        endcase
    endfunction

    // Mostly well-formed lines and blank runs, with some raw noise
    task automatic send_text(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0, 1: begin
                    len = $urandom_range(4, 1);
                    repeat (len) offer_char(CHAR_NL);
                    sent += len;
                end
                2: begin
                    len = $urandom_range(6, 1);
                    repeat (len) offer_char(8'($urandom_range(255)));
                    sent += len;
                end
                default: begin
                    len = $urandom_range(7);
                    repeat (len) offer_char(rand_text_char());
                    offer_char(CHAR_NL);
                    sent += len + 1;
                end
            endcase
        end
    endtask

    initial begin
        t_cfg opts;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text, no idling
        apply_opts(t_cfg'('1));
        for (int k = 0; k < FIRST_LEN; k++) begin
            offer_char(FIRST_TEXT[k]);
        end
        wait_idle();
        opts                = '0;
        opts.squeeze_enable = 1'b1;
        apply_opts(opts);
        for (int k = 0; k < SECOND_LEN; k++) begin
            offer_char(SECOND_TEXT[k]);
        end
        wait_idle();

        // Random text under changing options and idling
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       opts = t_cfg'('1);
                1:       opts = '0;
                default: opts = t_cfg'(5'($urandom_range(31)));
            endcase
            if (p == 5) begin
                opts.number_enable  = 1'b1;
                opts.squeeze_enable = 1'b0;
            end
            apply_opts(opts);
            case (p)
                1: begin
                    send_idle_pct  <= IDLE_HEAVY;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= IDLE_HEAVY;
                end
                3, 5: begin
                    send_idle_pct  <= IDLE_BOTH;
                    recv_stall_pct <= IDLE_BOTH;
                end
                default: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
            endcase
            // Fill the block behind a long output hold-off
            if (p == 4) begin
                hold_req <= hold_req + 1;
            end
            send_text(PHASE_ITEMS);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
